// File: rtl/core/tcp_retransmission_filter_defines.svh
// Assertion macros for the TCP retransmission filter checker.
// Expects clk and arst_n in the scope of use.
`ifndef TCP_RETRANSMISSION_FILTER_DEFINES_SVH
`define TCP_RETRANSMISSION_FILTER_DEFINES_SVH

// same-cycle implication
`define TRF_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("trf check failed");

// next-cycle implication
`define TRF_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("trf check failed");

`endif

// File: rtl/core/trf_pkg.sv
// Shared types and constants of the TCP retransmission filter.
// No dependencies.
`default_nettype none
package trf_pkg;

	typedef struct packed {
		logic        action;
		logic [63:0] addr_pair;
		logic [31:0] port_pair;
		logic [31:0] seq_num;
		logic [31:0] ack_num;
		logic [47:0] hdr_rest;
		logic [15:0] ip_total_len;
		logic [5:0]  ip_hdr_len;
		logic [7:0]  protocol;
		logic [12:0] frag_offset;
		logic [15:0] buffer_len;
		logic        skip_option;
	} trf_item_t;

	typedef struct packed {
		logic       drop;
		logic [2:0] status;
	} trf_res_t;

	typedef struct packed {
		logic [31:0] seq;
		logic [31:0] ack;
		logic [47:0] rest;
		logic [15:0] len;
	} trf_slot_t;

	typedef struct packed {
		logic latch;
		logic tick;
		logic scan_clr;
		logic ent_scan;
		logic sweep;
		logic slot_clr;
		logic slot_scan;
		logic chk;
		logic refresh;
		logic alloc_fill;
		logic store;
		logic inval;
	} trf_cmd_t;

	typedef struct packed {
		logic is_tick;
		logic qual;
		logic skip;
		logic scan_done;
		logic found;
		logic free;
		logic slot_done;
		logic dup;
		logic expired;
	} trf_stat_t;

	localparam logic [2:0] ST_NONE    = 3'd0;
	localparam logic [2:0] ST_NEW     = 3'd1;
	localparam logic [2:0] ST_STORED  = 3'd2;
	localparam logic [2:0] ST_DUP     = 3'd3;
	localparam logic [2:0] ST_SKIP    = 3'd4;
	localparam logic [2:0] ST_EXPIRED = 3'd5;
	localparam logic [2:0] ST_FULL    = 3'd6;
	localparam logic [2:0] ST_TICK    = 3'd7;

	localparam logic [7:0]  TCP_PROTO   = 8'd6;
	localparam logic [15:0] MIN_TCP_HDR = 16'd20;
	localparam logic [15:0] TIMEOUT_RST = 16'd10;

endpackage
`default_nettype wire

// File: rtl/core/tcp_retransmission_filter.sv
// TCP retransmission filter: one item at a time, one result per item.
// Packet: strobe after table scan, entry read and ring scan at most; new connection after
// table scan and slot fill, skipped segment after table scan and entry read, not candidate
// after qualification. Tick: strobe after the expiry sweep. New item taken with the strobe.
// Async reset clears time and valid bits and sets the timeout to 10; memories are not cleared.
// Results cannot be stalled; res_valid is a one-cycle strobe.
`default_nettype none
module tcp_retransmission_filter #(
	parameter int CONNS = 64,
	parameter int SLOTS = 8
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  trf_pkg::trf_item_t  item,
	output logic                res_valid,
	output trf_pkg::trf_res_t   res,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire  [15:0]         cfg_data
);
	import trf_pkg::*;

	trf_cmd_t  cmd;
	trf_stat_t stat;

	assign cfg_ready = 1'b1;

	trf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.res_valid (res_valid),
		.res       (res),
		.stat      (stat),
		.cmd       (cmd)
	);

	trf_dp #(
		.CONNS (CONNS),
		.SLOTS (SLOTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cfg_data (cfg_data),
		.cfg_we   (cfg_valid && cfg_ready),
		.cmd      (cmd),
		.stat     (stat)
	);

endmodule
`default_nettype wire

// File: rtl/core/trf_dp.sv
// Datapath: item register, qualifier, connection table, slot memory, time.
// Depends on trf_pkg.
`default_nettype none
module trf_dp #(
	parameter int CONNS = 64,
	parameter int SLOTS = 8
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  trf_pkg::trf_item_t   item,
	input  wire  [15:0]          cfg_data,
	input  wire                  cfg_we,
	input  trf_pkg::trf_cmd_t    cmd,
	output trf_pkg::trf_stat_t   stat
);
	import trf_pkg::*;

	localparam int CW  = (CONNS > 1) ? $clog2(CONNS) : 1;
	localparam int NCW = $clog2(CONNS + 1);
	localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int NSW = $clog2(SLOTS + 1);
	localparam int SDEPTH = CONNS << SW;

	trf_item_t     item_q;
	logic [15:0]   timeout_q;
	logic [31:0]   time_q;
	logic [CONNS-1:0] valid_q;

	logic [95:0]   key_mem  [CONNS];
	logic [31:0]   exp_mem  [CONNS];
	logic [SW-1:0] ring_mem [CONNS];
	trf_slot_t     slot_mem [SDEPTH];

	logic [95:0]   key_rd;
	logic [31:0]   exp_rd;
	logic [SW-1:0] ring_rd;
	trf_slot_t     slot_rd;

	logic [NCW-1:0] cnt_q;
	logic           pend_s1;
	logic [CW-1:0]  pidx_s1;
	logic           found_q, free_q;
	logic [CW-1:0]  fidx_q, free_idx_q;
	logic [NSW-1:0] scnt_q;
	logic           spend_s1;
	logic           dup_q;
	logic [31:0]    exp_q;
	logic [SW-1:0]  ring_q;

	logic [CW-1:0]  ent;
	logic [CW-1:0]  ent_ra;
	logic           issue, sissue;
	logic [15:0]    seglen;
	trf_slot_t      hdr;
	logic [17:0]    probe_len;
	logic [31:0]    new_exp;

	assign ent     = found_q ? fidx_q : free_idx_q;
	assign issue   = (cmd.ent_scan || cmd.sweep) && (cnt_q < NCW'(CONNS));
	assign sissue  = cmd.slot_scan && (scnt_q < NSW'(SLOTS));
	assign ent_ra  = issue ? cnt_q[CW-1:0] : ent;
	assign seglen  = item_q.ip_total_len - {10'd0, item_q.ip_hdr_len};
	assign hdr     = '{seq: item_q.seq_num, ack: item_q.ack_num,
			rest: item_q.hdr_rest, len: seglen};
	assign new_exp = time_q + {16'd0, timeout_q};
	assign probe_len = {2'b00, item_q.ip_total_len} - {12'd0, item_q.ip_hdr_len}
			- {12'd0, item_q.hdr_rest[47:44], 2'b00};

	always_comb begin
		stat.is_tick   = item_q.action;
		stat.qual      = (item_q.buffer_len >= MIN_TCP_HDR)
				&& (item_q.protocol == TCP_PROTO)
				&& (item_q.ip_total_len == item_q.buffer_len)
				&& (item_q.frag_offset == 13'd0)
				&& ({10'd0, item_q.ip_hdr_len} <= item_q.buffer_len)
				&& ((item_q.buffer_len - {10'd0, item_q.ip_hdr_len}) >= MIN_TCP_HDR);
		stat.skip      = (item_q.hdr_rest[33:32] != 2'b00)
				|| (item_q.hdr_rest[31:16] == 16'd0)
				|| (probe_len == 18'd1)
				|| item_q.skip_option;
		stat.scan_done = (cnt_q == NCW'(CONNS)) && !pend_s1;
		stat.found     = found_q;
		stat.free      = free_q;
		stat.slot_done = (scnt_q == NSW'(SLOTS)) && !spend_s1;
		stat.dup       = dup_q;
		stat.expired   = exp_q < time_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
			time_q    <= '0;
			valid_q   <= '0;
			cnt_q     <= '0;
			pend_s1   <= 1'b0;
			found_q   <= 1'b0;
			free_q    <= 1'b0;
			scnt_q    <= '0;
			spend_s1  <= 1'b0;
			dup_q     <= 1'b0;
		end else begin
			if (cfg_we)
				timeout_q <= cfg_data;
			if (cmd.tick)
				time_q <= time_q + 32'd1;
			if (cmd.scan_clr) begin
				cnt_q   <= '0;
				pend_s1 <= 1'b0;
				found_q <= 1'b0;
				free_q  <= 1'b0;
			end else begin
				pend_s1 <= issue;
				if (issue)
					cnt_q <= cnt_q + NCW'(1);
			end
			if (pend_s1) begin
				if (item_q.action) begin
					if (valid_q[pidx_s1] && (time_q > exp_rd))
						valid_q[pidx_s1] <= 1'b0;
				end else begin
					if (valid_q[pidx_s1] && (key_rd == {item_q.addr_pair, item_q.port_pair})
							&& !found_q)
						found_q <= 1'b1;
					if (!valid_q[pidx_s1] && !free_q)
						free_q <= 1'b1;
				end
			end
			if (cmd.slot_clr || cmd.scan_clr) begin
				scnt_q   <= '0;
				spend_s1 <= 1'b0;
				dup_q    <= 1'b0;
			end else begin
				spend_s1 <= sissue;
				if (sissue || (cmd.alloc_fill && (scnt_q < NSW'(SLOTS))))
					scnt_q <= scnt_q + NSW'(1);
				if (spend_s1 && (slot_rd == hdr))
					dup_q <= 1'b1;
			end
			if (cmd.alloc_fill)
				valid_q[ent] <= 1'b1;
			if (cmd.inval)
				valid_q[ent] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch)
			item_q <= item;
		pidx_s1 <= cnt_q[CW-1:0];
		if (pend_s1 && !item_q.action) begin
			if (valid_q[pidx_s1] && (key_rd == {item_q.addr_pair, item_q.port_pair})
					&& !found_q)
				fidx_q <= pidx_s1;
			if (!valid_q[pidx_s1] && !free_q)
				free_idx_q <= pidx_s1;
		end
		if (cmd.chk) begin
			exp_q  <= exp_rd;
			ring_q <= ring_rd;
		end
	end

	// entry memories
	always_ff @(posedge clk) begin
		key_rd  <= key_mem[ent_ra];
		exp_rd  <= exp_mem[ent_ra];
		ring_rd <= ring_mem[ent_ra];
		if (cmd.alloc_fill) begin
			key_mem[ent]  <= {item_q.addr_pair, item_q.port_pair};
			ring_mem[ent] <= SW'(1 % SLOTS);
		end
		if (cmd.store)
			ring_mem[ent] <= (ring_q == SW'(SLOTS - 1)) ? '0 : ring_q + SW'(1);
		if (cmd.alloc_fill || cmd.refresh || cmd.store)
			exp_mem[ent] <= new_exp;
	end

	// slot memory
	always_ff @(posedge clk) begin
		slot_rd <= slot_mem[{ent, scnt_q[SW-1:0]}];
		if (cmd.alloc_fill && (scnt_q < NSW'(SLOTS)))
			slot_mem[{ent, scnt_q[SW-1:0]}] <= (scnt_q == '0) ? hdr : '0;
		else if (cmd.store)
			slot_mem[{ent, ring_q}] <= hdr;
	end

endmodule
`default_nettype wire

// File: rtl/core/trf_ctrl.sv
// Controller state machine and result register.
// Depends on trf_pkg.
`default_nettype none
module trf_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	output logic                res_valid,
	output trf_pkg::trf_res_t   res,
	input  trf_pkg::trf_stat_t  stat,
	output trf_pkg::trf_cmd_t   cmd
);
	import trf_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_QUAL  = 8'b0000_0010,
		S_SWEEP = 8'b0000_0100,
		S_SRCH  = 8'b0000_1000,
		S_ALLOC = 8'b0001_0000,
		S_RDENT = 8'b0010_0000,
		S_CHK   = 8'b0100_0000,
		S_SLOT  = 8'b1000_0000
	} state_t;

	state_t     state_q, state_d;
	logic       done;
	logic [2:0] code;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		done    = 1'b0;
		code    = ST_NONE;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = S_QUAL;
				end
			end
			S_QUAL: begin
				cmd.scan_clr = 1'b1;
				if (stat.is_tick) begin
					cmd.tick = 1'b1;
					state_d  = S_SWEEP;
				end else if (stat.qual) begin
					state_d = S_SRCH;
				end else begin
					done    = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_SWEEP: begin
				cmd.sweep = 1'b1;
				if (stat.scan_done) begin
					done    = 1'b1;
					code    = ST_TICK;
					state_d = S_IDLE;
				end
			end
			S_SRCH: begin
				cmd.ent_scan = 1'b1;
				if (stat.scan_done) begin
					if (stat.found) begin
						state_d = S_RDENT;
					end else if (stat.free) begin
						cmd.slot_clr = 1'b1;
						state_d      = S_ALLOC;
					end else begin
						done    = 1'b1;
						code    = ST_FULL;
						state_d = S_IDLE;
					end
				end
			end
			S_ALLOC: begin
				cmd.alloc_fill = 1'b1;
				if (stat.slot_done) begin
					done    = 1'b1;
					code    = ST_NEW;
					state_d = S_IDLE;
				end
			end
			S_RDENT: begin
				state_d = S_CHK;
			end
			S_CHK: begin
				cmd.chk      = 1'b1;
				cmd.slot_clr = 1'b1;
				if (stat.skip) begin
					cmd.refresh = 1'b1;
					done        = 1'b1;
					code        = ST_SKIP;
					state_d     = S_IDLE;
				end else begin
					state_d = S_SLOT;
				end
			end
			S_SLOT: begin
				cmd.slot_scan = 1'b1;
				if (stat.slot_done) begin
					done    = 1'b1;
					state_d = S_IDLE;
					if (stat.dup) begin
						cmd.refresh = 1'b1;
						code        = ST_DUP;
					end else if (stat.expired) begin
						cmd.inval = 1'b1;
						code      = ST_EXPIRED;
					end else begin
						cmd.store = 1'b1;
						code      = ST_STORED;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			res_valid <= 1'b0;
		end else begin
			state_q   <= state_d;
			res_valid <= done;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			res.status <= code;
			res.drop   <= (code == ST_DUP);
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/trf_checker.sv
// Port-level checks of the TCP retransmission filter, bound to the top level.
// Depends on trf_pkg and tcp_retransmission_filter_defines.svh.
`default_nettype none
`include "tcp_retransmission_filter_defines.svh"
module trf_checker (
	input wire                clk,
	input wire                arst_n,
	input wire                start,
	input wire                busy,
	input wire                res_valid,
	input trf_pkg::trf_res_t  res
);
	import trf_pkg::*;

	`TRF_ASSERT_IMP(a_drop_dup, res_valid && res.drop, res.status == ST_DUP)
	`TRF_ASSERT_IMP(a_dup_drop, res_valid && (res.status == ST_DUP), res.drop)
	`TRF_ASSERT_NXT(a_accept_busy, start && !busy, busy)
	`TRF_ASSERT_NXT(a_one_strobe, res_valid, !res_valid)

endmodule

bind tcp_retransmission_filter trf_checker u_trf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.res_valid (res_valid),
	.res       (res)
);
`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for tcp_retransmission_filter: directed table, then random phases.
// Uses trf_pkg types and codes; predicts results with a model of the table or a directed row's known result.
`timescale 1ns / 1ps
module tb_top;
	import trf_pkg::*;

	localparam int CONNS = 64;
	localparam int SLOTS = 8;
	localparam int SETTLE = CONNS + SLOTS + 30;
	localparam int WDOG_LIMIT = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	trf_item_t item = '0;
	logic res_valid;
	trf_res_t res;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [15:0] cfg_data = '0;

	tcp_retransmission_filter #(.CONNS(CONNS), .SLOTS(SLOTS)) u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.res_valid(res_valid), .res(res),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// filter model state
	logic [15:0] timeout_s;
	logic [31:0] now_s;
	logic        ent_valid [CONNS];
	logic [63:0] ent_key [CONNS];
	logic [31:0] ent_ports [CONNS];
	logic [31:0] ent_expiry [CONNS];
	int          ent_next [CONNS];
	trf_slot_t   ent_slot [CONNS][SLOTS];

	trf_res_t pending_res[$];
	int fails = 0;
	int quiet_cycles = 0;
	logic row_known = 1'b0;
	trf_res_t row_res = '0;
	bit idle_on = 1'b1;

	function automatic trf_res_t filter_verdict(trf_item_t it);
		trf_res_t r;
		trf_slot_t cur;
		int tot, hl, bl, doff, hit, fr, e;
		r = '0;
		if (it.action) begin
			now_s = now_s + 32'd1;
			for (int i = 0; i < CONNS; i++)
				if (ent_valid[i] && now_s > ent_expiry[i])
					ent_valid[i] = 1'b0;
			r.status = ST_TICK;
			return r;
		end
		tot = it.ip_total_len;
		hl = it.ip_hdr_len;
		bl = it.buffer_len;
		if (bl < 20 || it.protocol != TCP_PROTO || tot != bl || it.frag_offset != 0 ||
				hl > bl || bl - hl < 20) begin
			r.status = ST_NONE;
			return r;
		end
		cur.seq = it.seq_num;
		cur.ack = it.ack_num;
		cur.rest = it.hdr_rest;
		cur.len = 16'(tot - hl);
		hit = -1;
		fr = -1;
		for (int i = 0; i < CONNS; i++) begin
			if (ent_valid[i]) begin
				if (hit < 0 && ent_key[i] == it.addr_pair && ent_ports[i] == it.port_pair)
					hit = i;
			end else if (fr < 0) begin
				fr = i;
			end
		end
		if (hit < 0) begin
			if (fr < 0) begin
				r.status = ST_FULL;
				return r;
			end
			ent_valid[fr] = 1'b1;
			ent_key[fr] = it.addr_pair;
			ent_ports[fr] = it.port_pair;
			for (int s = 0; s < SLOTS; s++)
				ent_slot[fr][s] = '0;
			ent_slot[fr][0] = cur;
			ent_next[fr] = 1 % SLOTS;
			ent_expiry[fr] = now_s + 32'(timeout_s);
			r.status = ST_NEW;
			return r;
		end
		e = hit;
		doff = int'(it.hdr_rest[47:44]) * 4;
		if (it.hdr_rest[33:32] != 2'b00 || it.hdr_rest[31:16] == 16'd0 ||
				(tot - hl - doff) == 1 || it.skip_option) begin
			ent_expiry[e] = now_s + 32'(timeout_s);
			r.status = ST_SKIP;
			return r;
		end
		for (int s = 0; s < SLOTS; s++)
			if (ent_slot[e][s] == cur) begin
				ent_expiry[e] = now_s + 32'(timeout_s);
				r.drop = 1'b1;
				r.status = ST_DUP;
				return r;
			end
		if (ent_expiry[e] < now_s) begin
			ent_valid[e] = 1'b0;
			r.status = ST_EXPIRED;
			return r;
		end
		ent_slot[e][ent_next[e]] = cur;
		ent_next[e] = (ent_next[e] + 1) % SLOTS;
		ent_expiry[e] = now_s + 32'(timeout_s);
		r.status = ST_STORED;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		trf_res_t exp_r, pr;
		if (!arst_n) begin
			timeout_s = TIMEOUT_RST;
			now_s = '0;
			for (int i = 0; i < CONNS; i++) begin
				ent_valid[i] = 1'b0;
				ent_next[i] = 0;
			end
		end else begin
			quiet_cycles = quiet_cycles + 1;
			if (res_valid) begin
				quiet_cycles = 0;
				if (pending_res.size() == 0) begin
					$error("result with nothing pending: drop=%0d status=%0d",
						res.drop, res.status);
					fails++;
				end else begin
					exp_r = pending_res.pop_front();
					if (res.drop !== exp_r.drop) begin
						$error("drop: expected %0d, got %0d", exp_r.drop, res.drop);
						fails++;
					end
					if (res.status !== exp_r.status) begin
						$error("status: expected %0d, got %0d", exp_r.status, res.status);
						fails++;
					end
				end
			end
			if (start && !busy) begin
				quiet_cycles = 0;
				pr = filter_verdict(item);
				pending_res.push_back(row_known ? row_res : pr);
			end
			if (cfg_valid && cfg_ready) begin
				quiet_cycles = 0;
				timeout_s = cfg_data;
			end
			if (quiet_cycles >= WDOG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic send_item(input trf_item_t it, input logic known, input trf_res_t kv);
		int n;
		@(negedge clk);
		start <= 1'b1;
		item <= it;
		row_known <= known;
		row_res <= kv;
		do @(posedge clk); while (busy);
		if (idle_on && $urandom_range(0, 99) < 50) begin
			@(negedge clk);
			start <= 1'b0;
			while (busy) @(negedge clk);
			n = $urandom_range(1, 60);
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending_res.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_timeout(input logic [15:0] v);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic trf_item_t mk_pkt(logic [63:0] a, logic [31:0] p, logic [31:0] sq,
			logic [31:0] ak, logic [47:0] rest, int tot, int hl, logic sk);
		trf_item_t it;
		it = '0;
		it.addr_pair = a;
		it.port_pair = p;
		it.seq_num = sq;
		it.ack_num = ak;
		it.hdr_rest = rest;
		it.ip_total_len = 16'(tot);
		it.ip_hdr_len = 6'(hl);
		it.protocol = TCP_PROTO;
		it.buffer_len = 16'(tot);
		it.skip_option = sk;
		return it;
	endfunction

	// clean segment; kind: 0 plain, 1 SYN/FIN, 2 zero window, 3 one-byte probe, 4 option
	function automatic trf_item_t clean_seg(logic [63:0] a, logic [31:0] p, int kind);
		logic [47:0] rest;
		int hl, doff, pay;
		hl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60) : 20;
		doff = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
		pay = $urandom_range(0, 120);
		if (pay == 1) pay = 0;
		rest = {$urandom(), 16'($urandom())};
		rest[47:44] = 4'(doff);
		rest[33:32] = 2'b00;
		if (rest[31:16] == 16'd0) rest[16] = 1'b1;
		case (kind)
			1: rest[33:32] = 2'($urandom_range(1, 3));
			2: rest[31:16] = 16'd0;
			3: pay = 1;
			default: ;
		endcase
		return mk_pkt(a, p, $urandom(), $urandom(), rest, hl + doff * 4 + pay, hl, kind == 4);
	endfunction

	trf_item_t  dir_item [$];
	logic       dir_known [$];
	trf_res_t   dir_res [$];

	task automatic add_row(input trf_item_t it, input logic known, input logic d,
			input logic [2:0] st);
		dir_item.push_back(it);
		dir_known.push_back(known);
		dir_res.push_back({d, st});
	endtask

	task automatic rand_phase(input int count, input int pool_n);
		logic [63:0] pool_a [8];
		logic [31:0] pool_p [8];
		trf_item_t sent [$];
		trf_item_t it;
		int r, k;
		for (int i = 0; i < pool_n; i++) begin
			pool_a[i] = {$urandom(), $urandom()};
			pool_p[i] = $urandom();
		end
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			k = $urandom_range(0, pool_n - 1);
			if (r < 8) begin
				it = '0;
				it.action = 1'b1;
			end else if (r < 16) begin
				it = {1'b0, {$urandom(), $urandom()}, $urandom(), $urandom(), $urandom(),
					48'({$urandom(), $urandom()}), 16'($urandom()), 6'($urandom_range(0, 60)),
					8'($urandom()), 13'($urandom()), 16'($urandom()), 1'($urandom())};
				if ($urandom_range(0, 1)) it.buffer_len = it.ip_total_len;
				if ($urandom_range(0, 1)) it.protocol = TCP_PROTO;
				if ($urandom_range(0, 1)) it.frag_offset = '0;
			end else if (r < 34 && sent.size() != 0) begin
				it = sent[$urandom_range(0, sent.size() - 1)];
			end else if (r < 44) begin
				it = clean_seg(pool_a[k], pool_p[k], $urandom_range(1, 4));
			end else begin
				it = clean_seg(pool_a[k], pool_p[k], 0);
				sent.push_back(it);
				if (sent.size() > 24) void'(sent.pop_front());
			end
			send_item(it, 1'b0, '0);
		end
	endtask

	initial begin
		trf_item_t t;
		logic [47:0] rst_rest;
		rst_rest = 48'h5000_1234_0000;
		t = '0;
		t.action = 1'b1;
		add_row(t, 1, 0, ST_TICK);
		t = mk_pkt('0, '0, 0, 0, rst_rest, 19, 0, 0);
		add_row(t, 1, 0, ST_NONE);
		t = mk_pkt('1, '1, 1, 1, rst_rest, 60, 20, 0);
		t.protocol = 8'hFF;
		add_row(t, 1, 0, ST_NONE);
		t = mk_pkt('1, '1, 1, 1, rst_rest, 60, 20, 0);
		t.frag_offset = 13'h1FFF;
		add_row(t, 1, 0, ST_NONE);
		t = mk_pkt('1, '1, 1, 1, rst_rest, 60, 20, 0);
		t.buffer_len = 16'd61;
		add_row(t, 1, 0, ST_NONE);
		t = mk_pkt('1, '1, 1, 1, rst_rest, 79, 60, 0);
		add_row(t, 1, 0, ST_NONE);
		t = mk_pkt('1, '1, '1, '1, 48'h5FFC_FFFF_FFFF, 100, 20, 0);
		add_row(t, 1, 0, ST_NEW);
		add_row(t, 1, 1, ST_DUP);
		t.seq_num = 32'd7;
		add_row(t, 0, 0, ST_STORED);
		t.hdr_rest[33] = 1'b1;
		add_row(t, 1, 0, ST_SKIP);
		t = mk_pkt('1, '1, 5, 5, 48'h5000_0000_0000, 100, 20, 0);
		add_row(t, 1, 0, ST_SKIP);
		t = mk_pkt('1, '1, 5, 5, 48'h5000_1000_0000, 41, 20, 0);
		add_row(t, 1, 0, ST_SKIP);
		t = mk_pkt('1, '1, 5, 5, 48'h5000_1000_0000, 200, 20, 1);
		add_row(t, 1, 0, ST_SKIP);
		t = mk_pkt('0, '0, 0, 0, 48'hF000_8000_0000, 65535, 60, 0);
		add_row(t, 1, 0, ST_NEW);
		t = mk_pkt('0, '0, 3, 0, 48'h5000_8000_0000, 1000, 21, 0);
		add_row(t, 0, 0, ST_STORED);
		t.hdr_rest[32] = 1'b1;
		add_row(t, 1, 0, ST_SKIP);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < dir_item.size(); i++)
			send_item(dir_item[i], dir_known[i], dir_res[i]);

		set_timeout(16'd1);
		rand_phase(265, 6);
		set_timeout(16'd0);
		idle_on = 1'b0;
		rand_phase(265, 6);
		idle_on = 1'b1;
		set_timeout(16'd3);
		rand_phase(265, 4);
		set_timeout(16'($urandom_range(2, 40)));
		rand_phase(265, 8);
		set_timeout(16'hFFFF);
		for (int i = 0; i < 70; i++)
			send_item(clean_seg({$urandom(), $urandom()}, $urandom(), 0), 1'b0, '0);
		rand_phase(200, 8);

		drain();
		if (fails == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule

// File: tcp_retransmission_filter.f
+incdir+rtl/core
rtl/core/trf_pkg.sv
rtl/core/trf_dp.sv
rtl/core/trf_ctrl.sv
rtl/core/tcp_retransmission_filter.sv
rtl/core/trf_checker.sv
bench/tb_top.sv
